>>> hw/rtl/i2cme_pkg.sv
package i2cme_pkg;

   // bus commands, same codes as the mode field
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // period index inside one command
   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SECOND = 3'd1,
      PH_THIRD  = 3'd2,
      PH_FOURTH = 3'd3,
      PH_FIFTH  = 3'd4
   } phase_type;

   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam logic [7:0]  ACK_LIMIT_RESET = 8'd255;
   localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
   localparam int unsigned REQ_DATA_W      = 16;
   localparam int unsigned RSP_DATA_W      = 16;
   localparam int unsigned MODE_W          = 3;
   localparam int unsigned LIMIT_W         = 8;

   // classified item between front and back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       more_follows;
      logic       sda_level;
   } item_type;

   // result item, scl_drive in the lowest bit
   typedef struct packed {
      logic       ack_timeout;
      logic       ack_seen;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       scl_drive;
   } result_type;

endpackage

>>> hw/rtl/i2cme_front.sv
module i2cme_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i2cme_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [i2cme_pkg::MODE_W-1:0]        req_tuser,
   input  logic                                q_ready,
   output logic                                q_push,
   output i2cme_pkg::item_type                 q_item
);

   i2cme_pkg::cmd_type cmd;

   // unused mode codes fall back to no command
   always_comb begin
      unique case (req_tuser)
         i2cme_pkg::CMD_START: cmd = i2cme_pkg::CMD_START;
         i2cme_pkg::CMD_STOP:  cmd = i2cme_pkg::CMD_STOP;
         i2cme_pkg::CMD_WRITE: cmd = i2cme_pkg::CMD_WRITE;
         i2cme_pkg::CMD_READ:  cmd = i2cme_pkg::CMD_READ;
         default:              cmd = i2cme_pkg::CMD_NONE;
      endcase
   end

   assign req_tready          = q_ready;
   assign q_push              = req_tvalid & q_ready;
   assign q_item.cmd          = cmd;
   assign q_item.tx_byte      = req_tdata[7:0];
   assign q_item.more_follows = req_tdata[8];
   assign q_item.sda_level    = req_tdata[9];

endmodule

>>> hw/rtl/i2cme_queue.sv
module i2cme_queue #(
   parameter int unsigned DEPTH = i2cme_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  i2cme_pkg::item_type  push_item,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output i2cme_pkg::item_type  pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   i2cme_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/i2cme_back.sv
module i2cme_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2cme_pkg::LIMIT_W-1:0]       csr_data,
   input  logic                                q_valid,
   input  i2cme_pkg::item_type                 q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output i2cme_pkg::result_type               rsp_result
);

   i2cme_pkg::cmd_type   cmd_ff, cmd_in, cmd_cur;
   i2cme_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [3:0] bits_ff, bits_in, bits_cur, bits_inc;
   logic [7:0] shift_ff, shift_in, shift_cur;
   logic [7:0] wait_ff, wait_in, wait_cur, wait_inc;
   logic       ackc_ff, ackc_in, ackc_cur;
   logic       scl_ff, scl_in, sda_ff, sda_in;
   logic [7:0] limit_ff, limit_eff;
   logic       out_valid_ff;
   i2cme_pkg::result_type out_ff, res;
   logic       start, step, ack_lvl;

   assign csr_ready  = 1'b1;
   assign step       = q_valid & (~out_valid_ff | rsp_tready);
   assign q_pop      = step;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   // a limit of zero polls once
   assign limit_eff = (limit_ff == '0) ? 8'd1 : limit_ff;

   // a new command is taken only when idle
   assign start = (cmd_ff == i2cme_pkg::CMD_NONE) && (q_item.cmd != i2cme_pkg::CMD_NONE);

   always_comb begin
      cmd_cur   = start ? q_item.cmd : cmd_ff;
      phase_cur = start ? i2cme_pkg::PH_FIRST : phase_ff;
      bits_cur  = start ? 4'd0 : bits_ff;
      wait_cur  = start ? 8'd0 : wait_ff;
      shift_cur = start ? ((q_item.cmd == i2cme_pkg::CMD_WRITE) ? q_item.tx_byte : 8'd0)
                        : shift_ff;
      ackc_cur  = start ? q_item.more_follows : ackc_ff;
      bits_inc  = bits_cur + 4'd1;
      wait_inc  = wait_cur + 8'd1;
      ack_lvl   = ~ackc_cur;

      cmd_in   = cmd_cur;
      phase_in = phase_cur;
      bits_in  = bits_cur;
      wait_in  = wait_cur;
      shift_in = shift_cur;
      ackc_in  = ackc_cur;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      res      = '0;
      res.scl_drive = scl_ff;
      res.sda_drive = sda_ff;

      unique case (cmd_cur)
         i2cme_pkg::CMD_START: begin
            res.busy_res  = 1'b1;
            res.scl_drive = 1'b1;
            if (phase_cur == i2cme_pkg::PH_FIRST) begin
               res.sda_drive = 1'b1;
               phase_in      = i2cme_pkg::PH_SECOND;
            end else begin
               res.sda_drive = 1'b0;
               res.done_res  = 1'b1;
               cmd_in        = i2cme_pkg::CMD_NONE;
               phase_in      = i2cme_pkg::PH_FIRST;
               scl_in        = 1'b0;
               sda_in        = 1'b0;
            end
         end
         i2cme_pkg::CMD_STOP: begin
            res.busy_res = 1'b1;
            unique case (phase_cur)
               i2cme_pkg::PH_FIRST: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = 1'b0;
                  phase_in      = i2cme_pkg::PH_SECOND;
               end
               i2cme_pkg::PH_SECOND: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = 1'b0;
                  phase_in      = i2cme_pkg::PH_THIRD;
               end
               i2cme_pkg::PH_THIRD: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = 1'b1;
                  phase_in      = i2cme_pkg::PH_FOURTH;
               end
               default: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = 1'b1;
                  res.done_res  = 1'b1;
                  cmd_in        = i2cme_pkg::CMD_NONE;
                  phase_in      = i2cme_pkg::PH_FIRST;
                  scl_in        = 1'b0;
                  sda_in        = 1'b1;
               end
            endcase
         end
         i2cme_pkg::CMD_WRITE: begin
            res.busy_res = 1'b1;
            unique case (phase_cur)
               i2cme_pkg::PH_FIRST: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = shift_cur[7];
                  phase_in      = i2cme_pkg::PH_SECOND;
               end
               i2cme_pkg::PH_SECOND: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = shift_cur[7];
                  shift_in      = {shift_cur[6:0], 1'b0};
                  bits_in       = bits_inc;
                  phase_in      = (bits_inc >= i2cme_pkg::BITS_PER_BYTE) ?
                                  i2cme_pkg::PH_THIRD : i2cme_pkg::PH_FIRST;
               end
               i2cme_pkg::PH_THIRD: begin
                  // ack poll with SCL held low
                  res.scl_drive = 1'b0;
                  res.sda_drive = 1'b1;
                  wait_in       = wait_inc;
                  if (!q_item.sda_level) begin
                     phase_in = i2cme_pkg::PH_FOURTH;
                  end else if (wait_inc >= limit_eff) begin
                     res.done_res    = 1'b1;
                     res.ack_timeout = 1'b1;
                     cmd_in          = i2cme_pkg::CMD_NONE;
                     phase_in        = i2cme_pkg::PH_FIRST;
                     scl_in          = 1'b0;
                     sda_in          = 1'b1;
                  end
               end
               i2cme_pkg::PH_FOURTH: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = 1'b1;
                  phase_in      = i2cme_pkg::PH_FIFTH;
               end
               default: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = 1'b1;
                  res.done_res  = 1'b1;
                  res.ack_seen  = 1'b1;
                  cmd_in        = i2cme_pkg::CMD_NONE;
                  phase_in      = i2cme_pkg::PH_FIRST;
                  scl_in        = 1'b0;
                  sda_in        = 1'b1;
               end
            endcase
         end
         i2cme_pkg::CMD_READ: begin
            res.busy_res = 1'b1;
            unique case (phase_cur)
               i2cme_pkg::PH_FIRST: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = 1'b1;
                  phase_in      = i2cme_pkg::PH_SECOND;
               end
               i2cme_pkg::PH_SECOND: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = 1'b1;
                  shift_in      = {shift_cur[6:0], q_item.sda_level};
                  bits_in       = bits_inc;
                  phase_in      = (bits_inc >= i2cme_pkg::BITS_PER_BYTE) ?
                                  i2cme_pkg::PH_THIRD : i2cme_pkg::PH_FIRST;
               end
               i2cme_pkg::PH_THIRD: begin
                  res.scl_drive = 1'b0;
                  res.sda_drive = ack_lvl;
                  phase_in      = i2cme_pkg::PH_FOURTH;
               end
               default: begin
                  res.scl_drive = 1'b1;
                  res.sda_drive = ack_lvl;
                  res.done_res  = 1'b1;
                  res.rx_byte   = shift_cur;
                  cmd_in        = i2cme_pkg::CMD_NONE;
                  phase_in      = i2cme_pkg::PH_FIRST;
                  scl_in        = 1'b0;
                  sda_in        = ack_lvl;
               end
            endcase
         end
         default: begin
            // idle: lines hold what the last command left
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cme_pkg::CMD_NONE;
         phase_ff <= i2cme_pkg::PH_FIRST;
         bits_ff  <= '0;
         shift_ff <= '0;
         wait_ff  <= '0;
         ackc_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         wait_ff  <= wait_in;
         ackc_ff  <= ackc_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= i2cme_pkg::ACK_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= res;
      end
   end

endmodule

>>> hw/rtl/i2c_master_byte_engine_unit.sv
// An accepted item goes into the queue, then into the result register on rsp.
// Throughput: one item per clock while results are taken, one bus delay period
// per item. On a result stall the queue fills to QUEUE_DEPTH items, then
// req_tready drops until the back end pops.
// Reset (synchronous, active high): idle, SCL and SDA released high, queue
// and result register empty, ack_wait_limit back to 255.
module i2c_master_byte_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = i2cme_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // config: ack_wait_limit
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [i2cme_pkg::LIMIT_W-1:0]     csr_data,
   // request items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] tx_byte, [8] more_follows, [9] sda_level, [15:10] zero
   input  logic [i2cme_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] mode
   input  logic [i2cme_pkg::MODE_W-1:0]      req_tuser,
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
   // [11:4] rx_byte, [12] ack_seen, [13] ack_timeout, [15:14] zero
   output logic [i2cme_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                  q_push, q_ready, q_valid, q_pop;
   i2cme_pkg::item_type   push_item, pop_item;
   i2cme_pkg::result_type rsp_result;

   // front: decode mode into a command, unused codes become no command
   i2cme_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // short queue so front and back can stall independently
   i2cme_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (pop_item)
   );

   // back: bus sequencer, one period per item, registered result
   i2cme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {{(i2cme_pkg::RSP_DATA_W - $bits(i2cme_pkg::result_type)){1'b0}},
                       rsp_result};

endmodule

>>> hw/rtl/i2cme_checker.sv
module i2cme_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2cme_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its bits
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // done only in a busy period
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("done without busy");

   // ack outcome and read data appear only with done, never both outcomes
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12] || rsp_tdata[13] || rsp_tdata[11:4] != 8'd0)
      |-> rsp_tdata[3] && !(rsp_tdata[12] && rsp_tdata[13]))
      else $error("outcome fields outside a done period");

endmodule

bind i2c_master_byte_engine_unit i2cme_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> verif/i2c_master_byte_engine_checker.sv
module i2c_master_byte_engine_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [i2cme_pkg::LIMIT_W-1:0]    csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [i2cme_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [i2cme_pkg::MODE_W-1:0]     req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [i2cme_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               outstanding,
   output int                               fail_count
);

   // shadow of the bus engine
   logic [i2cme_pkg::LIMIT_W-1:0] ack_limit;
   i2cme_pkg::cmd_type            cmd_q;
   i2cme_pkg::phase_type          phase_q;
   logic [3:0]                    bits_done;
   logic [7:0]                    shifter;
   logic [7:0]                    polls;
   logic                          answer_ack;
   logic                          scl_q;
   logic                          sda_q;

   // predicted results, one per accepted item, oldest first
   i2cme_pkg::result_type         period_q[$];
   i2cme_pkg::result_type         got_r;
   i2cme_pkg::result_type         want_r;
   i2cme_pkg::result_type         next_r;

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // command finished: lines rest at the given levels
   task automatic rest_lines(input logic scl, input logic sda);
      scl_q   = scl;
      sda_q   = sda;
      cmd_q   = i2cme_pkg::CMD_NONE;
      phase_q = i2cme_pkg::PH_FIRST;
   endtask

   task automatic advance_bus_period(input logic [2:0] mode, input logic [7:0] tx,
                                     input logic more, input logic sda_in,
                                     output i2cme_pkg::result_type r);
      logic [7:0] lim;
      logic       a;
      r = '0;
      {r.scl_drive, r.sda_drive} = {scl_q, sda_q};
      lim = (ack_limit == 8'd0) ? 8'd1 : ack_limit;
      if (cmd_q == i2cme_pkg::CMD_NONE && mode >= i2cme_pkg::CMD_START &&
          mode <= i2cme_pkg::CMD_READ) begin
         cmd_q      = i2cme_pkg::cmd_type'(mode);
         phase_q    = i2cme_pkg::PH_FIRST;
         bits_done  = '0;
         polls      = '0;
         shifter    = (i2cme_pkg::cmd_type'(mode) == i2cme_pkg::CMD_WRITE) ? tx : 8'h00;
         answer_ack = more;
      end
      if (cmd_q != i2cme_pkg::CMD_NONE) begin
         r.busy_res = 1'b1;
         case (cmd_q)
            i2cme_pkg::CMD_START: begin
               if (phase_q == i2cme_pkg::PH_FIRST) begin
                  {r.scl_drive, r.sda_drive} = 2'b11;
                  phase_q = i2cme_pkg::PH_SECOND;
               end else begin
                  {r.scl_drive, r.sda_drive} = 2'b10;
                  r.done_res = 1'b1;
                  rest_lines(1'b0, 1'b0);
               end
            end
            i2cme_pkg::CMD_STOP: begin
               case (phase_q)
                  i2cme_pkg::PH_FIRST: begin
                     {r.scl_drive, r.sda_drive} = 2'b00;
                     phase_q = i2cme_pkg::PH_SECOND;
                  end
                  i2cme_pkg::PH_SECOND: begin
                     {r.scl_drive, r.sda_drive} = 2'b10;
                     phase_q = i2cme_pkg::PH_THIRD;
                  end
                  i2cme_pkg::PH_THIRD: begin
                     {r.scl_drive, r.sda_drive} = 2'b11;
                     phase_q = i2cme_pkg::PH_FOURTH;
                  end
                  default: begin
                     {r.scl_drive, r.sda_drive} = 2'b01;
                     r.done_res = 1'b1;
                     rest_lines(1'b0, 1'b1);
                  end
               endcase
            end
            i2cme_pkg::CMD_WRITE: begin
               case (phase_q)
                  i2cme_pkg::PH_FIRST: begin
                     {r.scl_drive, r.sda_drive} = {1'b0, shifter[7]};
                     phase_q = i2cme_pkg::PH_SECOND;
                  end
                  i2cme_pkg::PH_SECOND: begin
                     {r.scl_drive, r.sda_drive} = {1'b1, shifter[7]};
                     shifter = shifter << 1;
                     bits_done++;
                     phase_q = (bits_done >= i2cme_pkg::BITS_PER_BYTE) ?
                               i2cme_pkg::PH_THIRD : i2cme_pkg::PH_FIRST;
                  end
                  i2cme_pkg::PH_THIRD: begin
                     // ack poll, SCL low, SDA released
                     {r.scl_drive, r.sda_drive} = 2'b01;
                     polls++;
                     if (!sda_in) begin
                        phase_q = i2cme_pkg::PH_FOURTH;
                     end else if (polls >= lim) begin
                        r.done_res    = 1'b1;
                        r.ack_timeout = 1'b1;
                        rest_lines(1'b0, 1'b1);
                     end
                  end
                  i2cme_pkg::PH_FOURTH: begin
                     {r.scl_drive, r.sda_drive} = 2'b11;
                     phase_q = i2cme_pkg::PH_FIFTH;
                  end
                  default: begin
                     {r.scl_drive, r.sda_drive} = 2'b01;
                     r.done_res = 1'b1;
                     r.ack_seen = 1'b1;
                     rest_lines(1'b0, 1'b1);
                  end
               endcase
            end
            default: begin
               a = ~answer_ack;
               case (phase_q)
                  i2cme_pkg::PH_FIRST: begin
                     {r.scl_drive, r.sda_drive} = 2'b01;
                     phase_q = i2cme_pkg::PH_SECOND;
                  end
                  i2cme_pkg::PH_SECOND: begin
                     {r.scl_drive, r.sda_drive} = 2'b11;
                     shifter = {shifter[6:0], sda_in};
                     bits_done++;
                     phase_q = (bits_done >= i2cme_pkg::BITS_PER_BYTE) ?
                               i2cme_pkg::PH_THIRD : i2cme_pkg::PH_FIRST;
                  end
                  i2cme_pkg::PH_THIRD: begin
                     {r.scl_drive, r.sda_drive} = {1'b0, a};
                     phase_q = i2cme_pkg::PH_FOURTH;
                  end
                  default: begin
                     {r.scl_drive, r.sda_drive} = {1'b1, a};
                     r.done_res = 1'b1;
                     r.rx_byte  = shifter;
                     rest_lines(1'b0, a);
                  end
               endcase
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ack_limit  = i2cme_pkg::ACK_LIMIT_RESET;
         cmd_q      = i2cme_pkg::CMD_NONE;
         phase_q    = i2cme_pkg::PH_FIRST;
         bits_done  = '0;
         shifter    = '0;
         polls      = '0;
         answer_ack = 1'b0;
         scl_q      = 1'b1;
         sda_q      = 1'b1;
         period_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            ack_limit = csr_data;
         if (req_tvalid && req_tready) begin
            advance_bus_period(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9], next_r);
            period_q.push_back(next_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r = i2cme_pkg::result_type'(rsp_tdata[$bits(i2cme_pkg::result_type)-1:0]);
            if (period_q.size() == 0) begin
               report_mismatch("unexpected item", int'(got_r), 0);
            end else begin
               want_r = period_q.pop_front();
               if (got_r.scl_drive !== want_r.scl_drive)
                  report_mismatch("scl_drive", int'(got_r.scl_drive),
                                  int'(want_r.scl_drive));
               if (got_r.sda_drive !== want_r.sda_drive)
                  report_mismatch("sda_drive", int'(got_r.sda_drive),
                                  int'(want_r.sda_drive));
               if (got_r.busy_res !== want_r.busy_res)
                  report_mismatch("busy_res", int'(got_r.busy_res), int'(want_r.busy_res));
               if (got_r.done_res !== want_r.done_res)
                  report_mismatch("done_res", int'(got_r.done_res), int'(want_r.done_res));
               if (got_r.rx_byte !== want_r.rx_byte)
                  report_mismatch("rx_byte", int'(got_r.rx_byte), int'(want_r.rx_byte));
               if (got_r.ack_seen !== want_r.ack_seen)
                  report_mismatch("ack_seen", int'(got_r.ack_seen), int'(want_r.ack_seen));
               if (got_r.ack_timeout !== want_r.ack_timeout)
                  report_mismatch("ack_timeout", int'(got_r.ack_timeout),
                                  int'(want_r.ack_timeout));
            end
         end
      end
      outstanding <= period_q.size();
   end

endmodule

>>> verif/tb_i2c_master_byte_engine_unit.sv
module tb_i2c_master_byte_engine_unit;

   // mode codes the block treats as no command
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   // receiver behaviors
   localparam int SINK_OPEN    = 0;   // always ready
   localparam int SINK_RANDOM  = 1;   // ready about 70% of cycles
   localparam int SINK_PATTERN = 2;   // rotating 12-bit mask
   localparam int SINK_SPARSE  = 3;   // ready about 30% of cycles

   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_SLACK      = 4;
   localparam int ITEM_BUDGET      = 1100;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [i2cme_pkg::LIMIT_W-1:0]    csr_data   = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [i2cme_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [i2cme_pkg::MODE_W-1:0]     req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [i2cme_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int outstanding;
   int fail_count;

   // stimulus shaping state
   int          items_sent   = 0;
   int          burst_left   = 0;
   bit          steady       = 1'b1;  // no sender gaps while set
   int          sink_style   = SINK_OPEN;
   logic [11:0] sink_pattern = 12'hFFF;
   bit          hold_req     = 1'b0;  // asks the receiver for one long hold
   int          poll_max     = 255;   // effective ack poll count at the block

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   i2c_master_byte_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   i2c_master_byte_engine_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // Receiver. Changes tready at the falling edge. A hold request from the
   // stimulus drops tready for a long counted stretch so the block backs up
   // and must stall its input side.
   initial begin
      int hold_left;
      int sink_tick;
      sink_tick = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req   = 1'b0;
            rsp_tready = 1'b0;
            hold_left  = LONG_HOLD_CYCLES;
            while (hold_left > 0) begin
               @(negedge clock);
               hold_left--;
            end
         end
         sink_tick++;
         case (sink_style)
            SINK_OPEN:    rsp_tready = 1'b1;
            SINK_RANDOM:  rsp_tready = ($urandom_range(0, 99) < 70);
            SINK_PATTERN: rsp_tready = sink_pattern[4'(sink_tick % 12)];
            default:      rsp_tready = ($urandom_range(0, 99) < 30);
         endcase
      end
   end

   // Offer one item; returns at the rising edge that accepts it. Bursts of
   // random length, random gaps between bursts unless steady is set.
   task automatic send_item(input logic [2:0] mode, input logic [7:0] tx,
                            input logic more, input logic sda);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (!steady) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {{(i2cme_pkg::REQ_DATA_W - 10){1'b0}}, sda, more, tx};
      req_tuser  = mode;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stop offering and wait until every predicted item has come back, then
   // let the back end settle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // ack_wait_limit is only written with the block idle
   task automatic write_ack_limit(input logic [7:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      poll_max  = (value == 8'd0) ? 1 : int'(value);
   endtask

   // Issue one command and feed exactly as many periods as it lasts.
   // Periods after the first carry mostly no command, sometimes a command
   // code that the busy block must ignore. For a write, ack_at picks the
   // poll period where SDA goes low; zero keeps SDA high into a timeout.
   task automatic run_cmd(input i2cme_pkg::cmd_type cmd, input logic [7:0] tx,
                          input logic more, input int ack_at);
      int         periods;
      logic       sda;
      logic [2:0] m;
      case (cmd)
         i2cme_pkg::CMD_START: periods = 2;
         i2cme_pkg::CMD_STOP:  periods = 4;
         i2cme_pkg::CMD_READ:  periods = 18;
         default:              periods = 16 + ((ack_at == 0) ? poll_max : ack_at + 2);
      endcase
      for (int p = 0; p < periods; p++) begin
         sda = 1'($urandom_range(0, 1));
         if (cmd == i2cme_pkg::CMD_WRITE && p >= 16)
            sda = (p - 15 == ack_at) ? 1'b0 : 1'b1;
         if (p == 0)
            m = cmd;
         else if ($urandom_range(0, 7) == 0)
            m = 3'($urandom_range(i2cme_pkg::CMD_START, MODE_UNUSED_HI));
         else
            m = i2cme_pkg::CMD_NONE;
         if (p == 0)
            send_item(m, tx, more, sda);
         else
            send_item(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
      end
   endtask

   // Idle periods between commands: no command or an unused mode code.
   task automatic idle_noise(input int count);
      logic [2:0] m;
      repeat (count) begin
         if ($urandom_range(0, 2) == 0)
            m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         else
            m = i2cme_pkg::CMD_NONE;
         send_item(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   // Poll period of the acknowledge, 0 for none. Timeouts only where the
   // limit is short enough to keep the run brief.
   function automatic int pick_ack();
      if (poll_max <= 16 && $urandom_range(0, 4) == 0)
         return 0;
      if (poll_max <= 16 && $urandom_range(0, 2) == 0)
         return $urandom_range(1, poll_max);
      return $urandom_range(1, (poll_max < 4) ? poll_max : 4);
   endfunction

   // Mostly framed transfers (start, address write, a few data bytes, stop)
   // with random content; the rest are stray commands and idle noise.
   task automatic random_phase(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            run_cmd(i2cme_pkg::CMD_START, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 0);
            run_cmd(i2cme_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), pick_ack());
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 1))
                  run_cmd(i2cme_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 0);
               else
                  run_cmd(i2cme_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), pick_ack());
            end
            run_cmd(i2cme_pkg::CMD_STOP, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 0);
         end else if (pick < 9) begin
            run_cmd(i2cme_pkg::cmd_type'($urandom_range(i2cme_pkg::CMD_START,
                                                        i2cme_pkg::CMD_READ)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_ack());
         end else begin
            idle_noise($urandom_range(1, 4));
         end
         if ($urandom_range(0, 2) == 0)
            idle_noise($urandom_range(1, 3));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, limit at its reset value, no idling on either side.
      // Idle period right after reset: lines released.
      send_item(i2cme_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
      // unused mode code acts as no command
      send_item(MODE_UNUSED_HI, 8'hFF, 1'b1, 1'b1);
      // start, with a read arriving in its last period: ignored, busy
      send_item(i2cme_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
      send_item(i2cme_pkg::CMD_READ, 8'hFF, 1'b1, 1'b0);
      // all-ones byte, acknowledged on the first poll
      run_cmd(i2cme_pkg::CMD_WRITE, 8'hFF, 1'b1, 1);
      run_cmd(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, 0);

      // Shortest limit: any late ack times out.
      write_ack_limit(8'd1);
      sink_style = SINK_RANDOM;
      steady     = 1'b0;
      random_phase(200);

      // Zero limit behaves as one poll. Receiver holds off for a long
      // stretch while the sender keeps offering back to back.
      write_ack_limit(8'd0);
      sink_style = SINK_OPEN;
      steady     = 1'b1;
      hold_req   = 1'b1;
      random_phase(150);

      // Longest limit, including one write that polls out the full count.
      write_ack_limit(8'd255);
      sink_style   = SINK_PATTERN;
      sink_pattern = 12'($urandom_range(1, 12'hFFF));
      steady       = 1'b0;
      run_cmd(i2cme_pkg::CMD_WRITE, 8'h00, 1'b0, 0);
      random_phase(120);

      // Short random limits, mixed receiver behavior.
      while (items_sent < ITEM_BUDGET) begin
         write_ack_limit(8'($urandom_range(2, 12)));
         sink_style   = $urandom_range(SINK_OPEN, SINK_SPARSE);
         sink_pattern = 12'($urandom_range(1, 12'hFFF));
         steady       = ($urandom_range(0, 3) == 0);
         random_phase(130);
      end

      wait_drained();
      if (fail_count == 0)
         $display("tb_i2c_master_byte_engine_unit: clean");
      else
         $display("tb_i2c_master_byte_engine_unit: errors");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_i2c_master_byte_engine_unit: errors");
      $finish;
   end

endmodule
